// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define ASSERT_CLK(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rtl assertion failed");

// concurrent check on the usual clk_i / rst_ni pair
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, prop, clk_i, rst_ni)

`endif

// ===== hw/rtl/chacha_pkg.sv =====
// shared constants, types and quarter-round function of the chacha20 block
package chacha_pkg;

  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned Words        = 16;
  localparam int unsigned IdxW         = $clog2(Words);
  // two steps per quarter round, column and diagonal half of each double round
  localparam int unsigned RndSteps     = DoubleRounds * 4;
  localparam int unsigned RndW         = (RndSteps > 1) ? $clog2(RndSteps) : 1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic            load;    // shift a new word into the state
    logic            round;   // one half quarter-round step on all four lanes
    logic            diag;    // diagonal lanes instead of column lanes
    logic            second;  // second half of the quarter round (rot 8, 7)
    logic            emit;    // capture one finished word into the output register
    logic [IdxW-1:0] idx;     // position of the emitted word
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a word this cycle
  } stat_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // half of the add-rotate-xor quarter round: two dependent adds
  function automatic qr_t qr_half(input word_t a, input word_t b, input word_t c,
                                  input word_t d, input logic second);
    qr_t   r;
    word_t ta;
    word_t tc;
    word_t xd;
    word_t xb;
    ta = a + b;
    xd = d ^ ta;
    r.d = second ? rotl(xd, 8) : rotl(xd, 16);
    tc = c + r.d;
    xb = b ^ tc;
    r.b = second ? rotl(xb, 7) : rotl(xb, 12);
    r.a = ta;
    r.c = tc;
    qr_half = r;
  endfunction

  function automatic word_t byte_rev(input word_t w);
    byte_rev = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ===== hw/rtl/chacha20_block_permute.sv =====
// top level of the word-serial chacha20 block function
//
// channel  dir  tdata              tuser           tlast
// s_axis   in   word_in [31:0]     -               -
// m_axis   out  word_out [31:0]    word_index[3:0] last_word
//
// a block is loaded as 16 input words, one per input transfer
// then the round phase: four quarter-round lanes, each quarter round in two steps
// then the 16 result words leave through the output register
// tready is low outside loading, so a new block is taken only after the last word is emitted
// reset drops any partly loaded block and restarts at word 0
// a stalled sink holds the emit phase; the output word stays until transferred
module chacha20_block_permute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // word_in [31:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // word_out [31:0]
  output logic [3:0]  m_axis_tuser_o,   // word_index [3:0]
  output logic        m_axis_tlast_o    // last_word
);

  chacha_pkg::cmd_t  cmd;
  chacha_pkg::stat_t stat;

  chacha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  chacha_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .word_i    (s_axis_tdata_i),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_index_o (m_axis_tuser_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

// ===== hw/rtl/chacha_datapath.sv =====
// state shift lines, four quarter-round lanes and output register
module chacha_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chacha_pkg::cmd_t             cmd_i,
  output chacha_pkg::stat_t            stat_o,
  input  logic [31:0]                  word_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [31:0]                  m_data_o,
  output logic [chacha_pkg::IdxW-1:0]  m_index_o,
  output logic                         m_last_o
);

  chacha_pkg::word_t wrk_q [chacha_pkg::Words];
  chacha_pkg::word_t wrk_d [chacha_pkg::Words];
  chacha_pkg::word_t sav_q [chacha_pkg::Words];

  logic                        out_valid_q;
  logic [31:0]                 out_data_q;
  logic [chacha_pkg::IdxW-1:0] out_index_q;
  logic                        out_last_q;

  always_comb begin
    chacha_pkg::qr_t             r;
    logic [chacha_pkg::IdxW-1:0] ia;
    logic [chacha_pkg::IdxW-1:0] ib;
    logic [chacha_pkg::IdxW-1:0] ic;
    logic [chacha_pkg::IdxW-1:0] id;
    wrk_d = wrk_q;
    r = '0;
    ia = '0;
    ib = '0;
    ic = '0;
    id = '0;
    if (cmd_i.load || cmd_i.emit) begin
      // word 0 leaves at the head, new word enters at the tail
      for (int unsigned k = 0; k < chacha_pkg::Words - 1; k++) begin
        wrk_d[k] = wrk_q[k+1];
      end
      wrk_d[chacha_pkg::Words-1] = word_i;
    end else if (cmd_i.round) begin
      for (int unsigned q = 0; q < 4; q++) begin
        ia = chacha_pkg::IdxW'(q);
        ib = chacha_pkg::IdxW'(cmd_i.diag ? 4 + ((q + 1) % 4)  : 4 + q);
        ic = chacha_pkg::IdxW'(cmd_i.diag ? 8 + ((q + 2) % 4)  : 8 + q);
        id = chacha_pkg::IdxW'(cmd_i.diag ? 12 + ((q + 3) % 4) : 12 + q);
        r = chacha_pkg::qr_half(wrk_q[ia], wrk_q[ib], wrk_q[ic], wrk_q[id], cmd_i.second);
        wrk_d[ia] = r.a;
        wrk_d[ib] = r.b;
        wrk_d[ic] = r.c;
        wrk_d[id] = r.d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wrk_q <= wrk_d;
    if (cmd_i.load || cmd_i.emit) begin
      for (int unsigned k = 0; k < chacha_pkg::Words - 1; k++) begin
        sav_q[k] <= sav_q[k+1];
      end
      sav_q[chacha_pkg::Words-1] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q  <= chacha_pkg::byte_rev(wrk_q[0] + sav_q[0]);
      out_index_q <= cmd_i.idx;
      out_last_q  <= (cmd_i.idx == chacha_pkg::IdxW'(chacha_pkg::Words - 1));
    end
  end

  assign stat_o.out_free = !out_valid_q || m_ready_i;
  assign m_valid_o       = out_valid_q;
  assign m_data_o        = out_data_q;
  assign m_index_o       = out_index_q;
  assign m_last_o        = out_last_q;

endmodule

// ===== hw/rtl/chacha_ctrl.sv =====
// sequencer for load, round and emit phases
`include "assert_macros.svh"

module chacha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  chacha_pkg::stat_t stat_i,
  output chacha_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StEmit
  } state_e;

  state_e                      state_q;
  state_e                      state_d;
  logic [chacha_pkg::IdxW-1:0] load_cnt_q;
  logic [chacha_pkg::IdxW-1:0] load_cnt_d;
  logic [chacha_pkg::RndW-1:0] rnd_cnt_q;
  logic [chacha_pkg::RndW-1:0] rnd_cnt_d;
  logic [chacha_pkg::IdxW-1:0] emit_cnt_q;
  logic [chacha_pkg::IdxW-1:0] emit_cnt_d;

  logic load_last;
  logic rnd_last;
  logic emit_last;

  assign load_last = (load_cnt_q == chacha_pkg::IdxW'(chacha_pkg::Words - 1));
  assign rnd_last  = (rnd_cnt_q == chacha_pkg::RndW'(chacha_pkg::RndSteps - 1));
  assign emit_last = (emit_cnt_q == chacha_pkg::IdxW'(chacha_pkg::Words - 1));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    rnd_cnt_d  = rnd_cnt_q;
    emit_cnt_d = emit_cnt_q;
    cmd_o      = '0;
    cmd_o.idx  = emit_cnt_q;
    // step counter: bit 0 picks the half, bit 1 column or diagonal
    cmd_o.second = rnd_cnt_q[0];
    cmd_o.diag   = (chacha_pkg::RndW > 1) ? rnd_cnt_q[chacha_pkg::RndW > 1 ? 1 : 0] : 1'b0;
    s_ready_o  = (state_q == StLoad);
    case (state_q)
      StLoad: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          load_cnt_d = load_cnt_q + chacha_pkg::IdxW'(1);
          if (load_last) begin
            rnd_cnt_d = '0;
            state_d   = StRound;
          end
        end
      end
      StRound: begin
        cmd_o.round = 1'b1;
        rnd_cnt_d   = rnd_cnt_q + chacha_pkg::RndW'(1);
        if (rnd_last) begin
          emit_cnt_d = '0;
          state_d    = StEmit;
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          emit_cnt_d = emit_cnt_q + chacha_pkg::IdxW'(1);
          if (emit_last) begin
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      load_cnt_q <= '0;
      rnd_cnt_q  <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      rnd_cnt_q  <= rnd_cnt_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  `ASSERT_STD(a_load_to_round,
              (state_q == StLoad && s_valid_i && load_last) |=>
              (state_q == StRound && rnd_cnt_q == '0))
  `ASSERT_STD(a_round_to_emit,
              (state_q == StRound && rnd_last) |=> (state_q == StEmit && emit_cnt_q == '0))
  `ASSERT_STD(a_emit_needs_room, cmd_o.emit |-> stat_i.out_free)
  `ASSERT_STD(a_load_count_idle, (state_q != StLoad) |-> (load_cnt_q == '0))

endmodule
